@@ design/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg - shared types and constants of the exhaustive tour search
// Sizes of the node, coordinate and cost paths and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // problem size and coordinate format
  localparam int MAX_NODES  = 8;
  localparam int COORD_BITS = 24;

  // derived widths
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int NODE_SLOTS = 1 << IDX_W;
  localparam int DEP_W      = $clog2(MAX_NODES + 1);
  localparam int TBL_AW     = 2 * IDX_W;
  localparam int TBL_DEPTH  = 1 << TBL_AW;
  localparam int DIST_W     = COORD_BITS + 1;
  localparam int COST_W     = DIST_W + $clog2(MAX_NODES);
  localparam int CMP_W      = (COST_W > 32) ? COST_W : 32;
  localparam int CFG_W      = 4;
  localparam int RES_W      = 32;

  // node count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  // best cost at the start of every search
  localparam logic [RES_W-1:0] BEST_INIT = 32'h7FFF_FFFF;

  // action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // write one node's coordinates
    logic build_clr;  // restart the distance table sweep
    logic build;      // run the distance table sweep
    logic root;       // place node 0 as the first path entry
    logic expand;     // pick the next candidate or pop the top level
    logic push;       // extend the path by the picked candidate
    logic close;      // score the closed tour
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic build_done;  // distance table fully written
    logic found;       // a candidate exists at the top level
    logic depth_one;   // only the start node is on the path
    logic n_is_one;    // single node problem
    logic close_next;  // the coming push completes a tour
  } sts_t;

endpackage

@@ design/tsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsp_ctrl - search sequencer
// Takes start transactions, runs the table sweep, then steps the backtracking
// search one action per state and marks the result with a one-cycle strobe.
// ----------------------------------------------------------------------------
module tsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          action_i,
  input  tsp_pkg::sts_t sts_i,
  output tsp_pkg::cmd_t cmd_o,
  output logic          busy,
  output logic          done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_ROOT,
    ST_EXPAND,
    ST_PUSH,
    ST_CLOSE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // decode next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i == tsp_pkg::ACT_SEARCH) begin
            cmd_o.build_clr = 1'b1;
            state_d         = ST_BUILD;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_BUILD: begin
        cmd_o.build = 1'b1;
        if (sts_i.build_done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root = 1'b1;
        state_d    = sts_i.n_is_one ? ST_CLOSE : ST_EXPAND;
      end
      ST_EXPAND: begin
        cmd_o.expand = 1'b1;
        if (sts_i.found) begin
          state_d = ST_PUSH;
        end else if (sts_i.depth_one) begin
          state_d = ST_DONE;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = sts_i.close_next ? ST_CLOSE : ST_EXPAND;
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        state_d     = ST_EXPAND;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  // result strobe lasts one cycle
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_IDLE))
    else $error("result strobe held longer than one cycle");

  // search ends only from a failed candidate pick
  a_done_from_expand : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> ($past(state_q) == ST_EXPAND))
    else $error("search finished outside a backtrack step");

endmodule

@@ design/tsp_dp.sv @@
// ----------------------------------------------------------------------------
// tsp_dp - search datapath
// Coordinate stores, distance table with its build pipeline, path and
// candidate stacks with running partial costs, visited mask, best cost and
// saturating step counter.
// ----------------------------------------------------------------------------
module tsp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tsp_pkg::cmd_t                       cmd_i,
  output tsp_pkg::sts_t                       sts_o,
  input  logic [tsp_pkg::IDX_W-1:0]           node_index_i,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] latitude_i,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] longitude_i,
  input  logic                                cfg_we_i,
  input  logic [tsp_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic [tsp_pkg::RES_W-1:0]           min_cost_o,
  output logic [tsp_pkg::RES_W-1:0]           calls_made_o
);

  localparam int IDX_W  = tsp_pkg::IDX_W;
  localparam int DEP_W  = tsp_pkg::DEP_W;
  localparam int CRD_W  = tsp_pkg::COORD_BITS;
  localparam int TBL_AW = tsp_pkg::TBL_AW;
  localparam int DIST_W = tsp_pkg::DIST_W;
  localparam int COST_W = tsp_pkg::COST_W;
  localparam int CMP_W  = tsp_pkg::CMP_W;
  localparam int CFG_W  = tsp_pkg::CFG_W;
  localparam int NODES  = tsp_pkg::MAX_NODES;
  localparam int SLOTS  = tsp_pkg::NODE_SLOTS;

  // configuration
  logic [CFG_W-1:0] cfg_q;
  logic [DEP_W-1:0] n_eff;

  // coordinate memories
  logic [CRD_W-1:0] lat_mem [SLOTS];
  logic [CRD_W-1:0] lon_mem [SLOTS];

  // table build pipeline
  logic [TBL_AW:0]       bld_cnt_q;
  logic                  bld_issue;
  logic                  v1_q, v2_q;
  logic [TBL_AW-1:0]     a1_q, a2_q;
  logic signed [CRD_W-1:0] lat_a_q, lat_b_q, lon_a_q, lon_b_q;
  logic signed [CRD_W:0] dlat_s, dlon_s;
  logic [CRD_W:0]        dlat_m, dlon_m;
  logic [CRD_W-1:0]      dlat_q, dlon_q;
  logic [DIST_W-1:0]     dist_wr;

  // distance table
  logic [DIST_W-1:0] tbl_mem [tsp_pkg::TBL_DEPTH];
  logic [TBL_AW-1:0] rd_addr;
  logic [DIST_W-1:0] dist_rd_q;

  // search state
  logic [IDX_W-1:0]  path_q [SLOTS];
  logic [DEP_W-1:0]  nc_q   [SLOTS];
  logic [COST_W-1:0] cost_q [SLOTS];
  logic [NODES-1:0]  visited_q;
  logic [DEP_W-1:0]  depth_q;
  logic [DEP_W-1:0]  top_full;
  logic [IDX_W-1:0]  top_idx;
  logic [IDX_W-1:0]  dep_idx;
  logic [IDX_W-1:0]  c_q;
  logic [IDX_W-1:0]  c_sel;
  logic [NODES-1:0]  avail;
  logic              found;
  logic [NODES-1:0]  c_oh;
  logic [NODES-1:0]  top_oh;
  logic [COST_W-1:0] sum;
  logic [CMP_W-1:0]  sum_x;
  logic [tsp_pkg::RES_W-1:0] best_q;
  logic [tsp_pkg::RES_W-1:0] count_q;

  // hold node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tsp_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // clamp node count to the supported range
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = DEP_W'(1);
    end else if (cfg_q > CFG_W'(NODES)) begin
      n_eff = DEP_W'(NODES);
    end else begin
      n_eff = DEP_W'(cfg_q);
    end
  end

  // write coordinates, read two nodes per sweep step
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (int'(node_index_i) < NODES)) begin
      lat_mem[node_index_i] <= latitude_i;
      lon_mem[node_index_i] <= longitude_i;
    end
    lat_a_q <= lat_mem[bld_cnt_q[TBL_AW-1:IDX_W]];
    lat_b_q <= lat_mem[bld_cnt_q[IDX_W-1:0]];
    lon_a_q <= lon_mem[bld_cnt_q[TBL_AW-1:IDX_W]];
    lon_b_q <= lon_mem[bld_cnt_q[IDX_W-1:0]];
  end

  assign bld_issue = cmd_i.build && !bld_cnt_q[TBL_AW];

  // advance sweep counter and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bld_cnt_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      if (cmd_i.build_clr) begin
        bld_cnt_q <= '0;
      end else if (bld_issue) begin
        bld_cnt_q <= bld_cnt_q + (TBL_AW + 1)'(1);
      end
      v1_q <= bld_issue;
      v2_q <= v1_q;
    end
  end

  // absolute coordinate differences
  always_comb begin
    dlat_s = {lat_a_q[CRD_W-1], lat_a_q} - {lat_b_q[CRD_W-1], lat_b_q};
    dlon_s = {lon_a_q[CRD_W-1], lon_a_q} - {lon_b_q[CRD_W-1], lon_b_q};
    dlat_m = dlat_s[CRD_W] ? 
             (CRD_W + 1)'(-dlat_s) : (CRD_W + 1)'(dlat_s);
    dlon_m = dlon_s[CRD_W] ?
             (CRD_W + 1)'(-dlon_s) : (CRD_W + 1)'(dlon_s);
    dist_wr = {1'b0, dlat_q} + {1'b0, dlon_q};
  end

  // carry addresses and differences down the pipeline
  always_ff @(posedge clk_i) begin
    a1_q   <= bld_cnt_q[TBL_AW-1:0];
    a2_q   <= a1_q;
    dlat_q <= dlat_m[CRD_W-1:0];
    dlon_q <= dlon_m[CRD_W-1:0];
  end

  // distance table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      tbl_mem[a2_q] <= dist_wr;
    end
    dist_rd_q <= tbl_mem[rd_addr];
  end

  // top of the path stack
  assign top_full = depth_q - DEP_W'(1);
  assign top_idx  = top_full[IDX_W-1:0];
  assign dep_idx  = depth_q[IDX_W-1:0];

  // first unvisited node at or after the top level's candidate
  always_comb begin
    for (int k = 0; k < NODES; k++) begin
      avail[k] = !visited_q[k] && (DEP_W'(k) >= nc_q[top_idx]) && (DEP_W'(k) < n_eff);
    end
    c_sel = '0;
    for (int k = NODES - 1; k >= 0; k--) begin
      if (avail[k]) begin
        c_sel = IDX_W'(k);
      end
    end
  end

  assign found  = (|avail) && (depth_q < n_eff);
  assign c_oh   = {{(NODES-1){1'b0}}, 1'b1} << c_q;
  assign top_oh = {{(NODES-1){1'b0}}, 1'b1} << path_q[top_idx];
  assign sum    = cost_q[top_idx] + COST_W'(dist_rd_q);
  assign sum_x  = CMP_W'(sum);

  // edge to look up next cycle
  always_comb begin
    if (cmd_i.push) begin
      rd_addr = {c_q, IDX_W'(0)};
    end else if (cmd_i.root) begin
      rd_addr = '0;
    end else begin
      rd_addr = {path_q[top_idx], c_sel};
    end
  end

  // stack payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.root) begin
      path_q[0] <= '0;
      nc_q[0]   <= '0;
      cost_q[0] <= '0;
    end
    if (cmd_i.expand && found) begin
      c_q <= c_sel;
    end
    if (cmd_i.push) begin
      nc_q[top_idx]   <= DEP_W'(c_q) + DEP_W'(1);
      path_q[dep_idx] <= c_q;
      nc_q[dep_idx]   <= '0;
      cost_q[dep_idx] <= sum;
    end
  end

  // search control state, best cost and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      depth_q   <= '0;
      best_q    <= '1;
      count_q   <= '0;
    end else begin
      if (cmd_i.root) begin
        visited_q <= {{(NODES-1){1'b0}}, 1'b1};
        depth_q   <= DEP_W'(1);
        best_q    <= tsp_pkg::BEST_INIT;
        count_q   <= 32'd1;
      end
      // drop the top node when no candidate remains
      if (cmd_i.expand && !found) begin
        visited_q <= visited_q & ~top_oh;
        depth_q   <= top_full;
      end
      if (cmd_i.push) begin
        visited_q <= visited_q | c_oh;
        depth_q   <= depth_q + DEP_W'(1);
        if (count_q != '1) begin
          count_q <= count_q + 32'd1;
        end
      end
      // keep the cheaper closed tour
      if (cmd_i.close && (sum_x < CMP_W'(best_q))) begin
        best_q <= sum_x[31:0];
      end
    end
  end

  assign sts_o.build_done = bld_cnt_q[TBL_AW] && !v1_q && !v2_q;
  assign sts_o.found      = found;
  assign sts_o.depth_one  = (depth_q == DEP_W'(1));
  assign sts_o.n_is_one   = (n_eff == DEP_W'(1));
  assign sts_o.close_next = ((depth_q + DEP_W'(1)) == n_eff);

  assign min_cost_o   = best_q;
  assign calls_made_o = count_q;

  // every node on the path is marked, nothing else
  a_mask_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(visited_q) == int'(depth_q))
    else $error("visited mask disagrees with path depth");

  // path never grows past the node count
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= n_eff)
    else $error("path depth beyond node count");

endmodule

@@ design/tsp_exhaustive_tour_search.sv @@
// ----------------------------------------------------------------------------
// tsp_exhaustive_tour_search - brute force travelling salesman search
// Loads node coordinates and finds the cheapest closed Manhattan tour from
// node 0 by exhaustive backtracking.
// ----------------------------------------------------------------------------
// A load transaction (action 0) leaves busy low, so a new load can be
// taken every cycle. A search transaction (action 1) raises busy; it
// first sweeps the distance table of 64 entries, then each extension of a
// partial path (counted in calls_made) costs a candidate pick and a push,
// each level is later popped once, and each of the (n-1)! complete tours
// is scored in a close step. The pace is set by the single distance table
// read port, used once per step. The result appears for one cycle with
// done_o and cannot be stalled; busy falls in the cycle after it.
// ----------------------------------------------------------------------------
module tsp_exhaustive_tour_search (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  action_i,
  input  logic [tsp_pkg::IDX_W-1:0]             node_index_i,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] latitude_i,
  input  logic signed [tsp_pkg::COORD_BITS-1:0] longitude_i,
  input  logic                                  cfg_we_i,
  input  logic [tsp_pkg::CFG_W-1:0]             cfg_wdata_i,
  output logic                                  done_o,
  output logic [tsp_pkg::RES_W-1:0]             min_cost_o,
  output logic [tsp_pkg::RES_W-1:0]             calls_made_o
);

  tsp_pkg::cmd_t cmd;
  tsp_pkg::sts_t sts;

  // sequencer
  tsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // storage and arithmetic
  tsp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .node_index_i (node_index_i),
    .latitude_i   (latitude_i),
    .longitude_i  (longitude_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .min_cost_o   (min_cost_o),
    .calls_made_o (calls_made_o)
  );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for the exhaustive tour search
// Loads node coordinates, runs searches over a range of node counts and
// checks every reported tour cost and step count against a local
// backtracking predictor. Mismatches are counted and summarized at the end.
// ----------------------------------------------------------------------------
module tb;

  localparam int RES_W      = tsp_pkg::RES_W;
  localparam int IDX_W      = tsp_pkg::IDX_W;
  localparam int COORD_BITS = tsp_pkg::COORD_BITS;
  localparam int CFG_W      = tsp_pkg::CFG_W;
  localparam int NODE_SLOTS = tsp_pkg::NODE_SLOTS;
  localparam int MAX_NODES  = tsp_pkg::MAX_NODES;

  localparam int CLK_HALF    = 2;
  localparam int DRAIN_LIMIT = 200000;     // cycles, above one 8-node search
  localparam int SETTLE      = 4;          // cycles after the last result
  localparam int RUN_LIMIT   = 100000000;  // time units, watchdog limit

  typedef struct packed {
    logic [RES_W-1:0] cost;
    logic [RES_W-1:0] steps;
  } tour_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic                         action_i;
  logic [IDX_W-1:0]             node_index_i;
  logic signed [COORD_BITS-1:0] latitude_i;
  logic signed [COORD_BITS-1:0] longitude_i;
  logic                         cfg_we_i;
  logic [CFG_W-1:0]             cfg_wdata_i;
  logic                         done_o;
  logic [RES_W-1:0]             min_cost_o;
  logic [RES_W-1:0]             calls_made_o;

  // local copy of the block's coordinates and node count
  logic signed [COORD_BITS-1:0] lat_mem [NODE_SLOTS];
  logic signed [COORD_BITS-1:0] lon_mem [NODE_SLOTS];
  logic [CFG_W-1:0]             node_cfg = tsp_pkg::CFG_RESET;

  tour_result_t pending_tours [$];
  tour_result_t seen_tour;

  int unsigned error_count  = 0;
  int unsigned load_count   = 0;
  int unsigned search_count = 0;
  int unsigned tour_checks  = 0;
  int unsigned cfg_writes   = 0;
  bit          quiet        = 1'b0;

  tsp_exhaustive_tour_search u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .node_index_i (node_index_i),
    .latitude_i   (latitude_i),
    .longitude_i  (longitude_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .min_cost_o   (min_cost_o),
    .calls_made_o (calls_made_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                 input logic [RES_W-1:0] want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // enumerate every tour from node 0; return the cheapest cost and step count
  function automatic void predict_tour(output logic [RES_W-1:0] best,
                                       output logic [RES_W-1:0] steps);
    longint      span [NODE_SLOTS][NODE_SLOTS];
    int unsigned path [NODE_SLOTS];
    int unsigned cand [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] seen;
    int unsigned n, lvl, c;
    longint      dl, dn, tour;
    bit          pushed;
    n = (node_cfg == 0) ? 1 : ((node_cfg > MAX_NODES) ? MAX_NODES : node_cfg);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        dl = longint'(lat_mem[i]) - longint'(lat_mem[j]);
        dn = longint'(lon_mem[i]) - longint'(lon_mem[j]);
        span[i][j] = ((dl < 0) ? -dl : dl) + ((dn < 0) ? -dn : dn);
      end
    end
    // root the path at node 0
    best    = tsp_pkg::BEST_INIT;
    steps   = RES_W'(1);
    path[0] = 0;
    cand[0] = 0;
    seen    = NODE_SLOTS'(1);
    lvl     = 1;
    pushed  = 1'b1;
    while (lvl > 0) begin
      // score a freshly completed tour
      if (pushed && lvl == n) begin
        tour = span[path[n-1]][path[0]];
        for (int i = 1; i < n; i++) tour += span[path[i-1]][path[i]];
        if (tour > longint'(32'hFFFF_FFFF)) tour = longint'(32'hFFFF_FFFF);
        if (longint'(best) > tour) best = tour[RES_W-1:0];
      end
      pushed = 1'b0;
      c = cand[lvl-1];
      while (c < n && seen[c]) c++;
      if (c < n && lvl < n) begin
        // extend the path by the next free node
        cand[lvl-1] = c + 1;
        if (steps != '1) steps++;
        path[lvl] = c;
        seen[c]   = 1'b1;
        cand[lvl] = 0;
        lvl++;
        pushed = 1'b1;
      end else begin
        // drop the top level
        seen[path[lvl-1]] = 1'b0;
        lvl--;
      end
    end
  endfunction

  // pick a coordinate: extremes, a small value or anything
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      2:       return COORD_BITS'(int'($urandom_range(0, 2000)) - 1000);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // offer one transaction, hold it until accepted, then predict
  task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                           input logic signed [COORD_BITS-1:0] lat,
                           input logic signed [COORD_BITS-1:0] lon);
    tour_result_t want;
    start        <= 1'b1;
    action_i     <= act;
    node_index_i <= idx;
    latitude_i   <= lat;
    longitude_i  <= lon;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (act == tsp_pkg::ACT_LOAD) begin
      lat_mem[idx] = lat;
      lon_mem[idx] = lon;
      load_count++;
    end else begin
      predict_tour(want.cost, want.steps);
      pending_tours.push_back(want);
      search_count++;
    end
    // idle the sender for a random burst now and then
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // wait for every pending result, then let the block settle
  task automatic drain_tours();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while (pending_tours.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (pending_tours.size() != 0) begin
      report_mismatch("searches without result", pending_tours.size(), 0);
      pending_tours.delete();
    end
  endtask

  // write the node count while the block is idle
  task automatic set_node_count(input logic [CFG_W-1:0] value);
    drain_tours();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_cfg = value;
    cfg_writes++;
  endtask

  // load every node, extremes on the first and last, then search at reset count
  task automatic test_reset_count();
    send_item(tsp_pkg::ACT_LOAD, IDX_W'(0), {1'b1, {(COORD_BITS-1){1'b0}}},
              {1'b1, {(COORD_BITS-1){1'b0}}});
    for (int i = 1; i < NODE_SLOTS - 1; i++) begin
      send_item(tsp_pkg::ACT_LOAD, IDX_W'(i), rand_coord(), rand_coord());
    end
    send_item(tsp_pkg::ACT_LOAD, IDX_W'(NODE_SLOTS - 1), {1'b0, {(COORD_BITS-1){1'b1}}},
              {1'b0, {(COORD_BITS-1){1'b1}}});
    send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
  endtask

  // single node, zero count and the widest two-node tour
  task automatic test_small_counts();
    set_node_count(CFG_W'(1));
    send_item(tsp_pkg::ACT_SEARCH, '0, '0, '0);
    set_node_count(CFG_W'(0));
    send_item(tsp_pkg::ACT_SEARCH, '1, '1, '1);
    set_node_count(CFG_W'(2));
    send_item(tsp_pkg::ACT_LOAD, IDX_W'(0), {1'b0, {(COORD_BITS-1){1'b1}}},
              {1'b1, {(COORD_BITS-1){1'b0}}});
    send_item(tsp_pkg::ACT_LOAD, IDX_W'(1), {1'b1, {(COORD_BITS-1){1'b0}}},
              {1'b0, {(COORD_BITS-1){1'b1}}});
    send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
  endtask

  // counts above the node limit clamp to the full problem
  task automatic test_count_saturation();
    set_node_count(CFG_W'(15));
    send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
    set_node_count(CFG_W'(9));
    send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
  endtask

  // hold the next transaction on start while a search runs
  task automatic test_back_to_back();
    quiet = 1'b1;
    set_node_count(CFG_W'(3));
    send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
    send_item(tsp_pkg::ACT_LOAD, IDX_W'(2), rand_coord(), rand_coord());
    send_item(tsp_pkg::ACT_LOAD, IDX_W'(5), rand_coord(), rand_coord());
    send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
    send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
    quiet = 1'b0;
  endtask

  // phases of random loads and searches, mostly small node counts
  task automatic test_random_traffic();
    int unsigned items, pick;
    logic [CFG_W-1:0] cnt;
    bit big_done;
    items    = 0;
    big_done = 1'b0;
    while (items < 78) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        cnt = CFG_W'(0);
      end else if (pick < 12) begin
        cnt = CFG_W'(7);
      end else if (pick < 15 && !big_done) begin
        cnt      = CFG_W'($urandom_range(8, 15));
        big_done = 1'b1;
      end else begin
        cnt = CFG_W'($urandom_range(1, 6));
      end
      set_node_count(cnt);
      repeat ($urandom_range(2, 8)) begin
        quiet = (items >= 68);
        if ($urandom_range(0, 9) < 4) begin
          send_item(tsp_pkg::ACT_SEARCH, IDX_W'($urandom), rand_coord(), rand_coord());
        end else begin
          send_item(tsp_pkg::ACT_LOAD, IDX_W'($urandom), rand_coord(), rand_coord());
        end
        items++;
      end
    end
  endtask

  // check each result against the oldest pending search
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_tours.size() == 0) begin
        report_mismatch("result with no search pending", min_cost_o, '0);
      end else begin
        seen_tour = pending_tours.pop_front();
        if (min_cost_o !== seen_tour.cost) begin
          report_mismatch("min_cost", min_cost_o, seen_tour.cost);
        end
        if (calls_made_o !== seen_tour.steps) begin
          report_mismatch("calls_made", calls_made_o, seen_tour.steps);
        end
        tour_checks++;
      end
    end
  end

  // stimulus
  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    action_i     <= tsp_pkg::ACT_LOAD;
    node_index_i <= '0;
    latitude_i   <= '0;
    longitude_i  <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_count();
    test_small_counts();
    test_count_saturation();
    test_back_to_back();
    test_random_traffic();
    drain_tours();
    $display("Run covered %0d node loads and %0d searches over %0d node count writes",
             load_count, search_count, cfg_writes);
    $display("Checked %0d search results, %0d mismatches", tour_checks, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT;
    $display("Timeout with %0d searches still pending", pending_tours.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
